// ===== rtl/core/bae_pkg.sv =====
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants for the carryless binary arithmetic encoder.
// ----------------------------------------------------------------------------
package bae_pkg;

   localparam int unsigned IntervalBits = 32;
   localparam int unsigned ByteBits     = 8;

   localparam logic [IntervalBits-1:0] LowReset  = 32'h0000_0000;
   localparam logic [IntervalBits-1:0] HighReset = 32'hFFFF_FFFF;
   localparam logic [ByteBits-1:0]     ByteFill  = 8'hFF;

   // Operation codes on req_operation
   localparam logic OpCodeBit = 1'b0;
   localparam logic OpFlush   = 1'b1;

   // One queued emission: up to four bytes taken MSB first from data.
   typedef struct packed {
      logic [IntervalBits-1:0] data;
      logic [1:0]              last_idx;   // index of final byte (count - 1)
   } job_type;

endpackage

// ===== rtl/core/binary_arithmetic_encoder_top.sv =====
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_top
// Carryless binary arithmetic encoder with a 32-bit interval.
// ----------------------------------------------------------------------------
// Each req_ transfer either codes one bit under a PROB_BITS-wide probability
// of one (zero is taken as one) or, with req_operation set, flushes the four
// bytes of the low bound and restarts the interval. Bytes leave on the rsp_
// channel most significant first; rsp_last_of_run marks the final byte that
// one item caused, and a coded bit that settles no byte produces no transfer.
// Flow: a coded bit occupies the front end through accept and
// span-times-probability multiply, interval split, then normalize and
// enqueue; a flush skips the split. The front end holds req_stall high while
// it works, and its enqueue step waits there for as long as the job queue is
// full. The back end emits one byte per cycle from the queue while rsp_stall
// is low, so long byte runs stall the input only once QUEUE_DEPTH jobs are
// waiting. The 32 x PROB_BITS multiply is the widest path.
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder_top #(
   parameter int unsigned PROB_BITS   = 12,
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   // item input
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic                 req_coded_bit,
   input  logic [PROB_BITS-1:0] req_probability_one,
   // byte output
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_run
);

   // front -> queue
   logic              push;
   bae_pkg::job_type  push_job;
   logic              queue_full;
   // queue -> back
   logic              pop;
   bae_pkg::job_type  head_job;
   logic              queue_empty;

   // Interval state, multiply and renormalization count
   bae_front #(
      .PROB_BITS (PROB_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_coded_bit       (req_coded_bit),
      .req_probability_one (req_probability_one),
      .push                (push),
      .push_job            (push_job),
      .queue_full          (queue_full)
   );

   // Decouples the interval update from the output handshake
   bae_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   // Byte serializer with registered output stage
   bae_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .empty           (queue_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== rtl/core/bae_front.sv =====
// ----------------------------------------------------------------------------
// bae_front
// Accepts items, updates the coding interval and queues settled bytes.
// ----------------------------------------------------------------------------
module bae_front #(
   parameter int unsigned PROB_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_operation,
   input  logic                    req_coded_bit,
   input  logic [PROB_BITS-1:0]    req_probability_one,
   output logic                    push,
   output bae_pkg::job_type        push_job,
   input  logic                    queue_full
);

   localparam int unsigned ProdBits = bae_pkg::IntervalBits + PROB_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_NORM
   } state_type;

   state_type                          state_ff, state_in;
   logic [bae_pkg::IntervalBits-1:0]   low_ff, low_in;
   logic [bae_pkg::IntervalBits-1:0]   high_ff, high_in;
   logic [ProdBits-1:0]                product_ff, product_in;
   logic                               bit_ff, bit_in;
   logic                               flush_ff, flush_in;

   logic                               accept;
   logic [PROB_BITS-1:0]               prob_clamped;
   logic [bae_pkg::IntervalBits-1:0]   span;
   logic [bae_pkg::IntervalBits-1:0]   mid;
   logic [bae_pkg::IntervalBits-1:0]   diff;
   logic [2:0]                         settled;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Zero maps to one; the upper bound is already the field maximum.
   assign prob_clamped = (req_probability_one == '0) ? PROB_BITS'(1) : req_probability_one;
   assign span         = high_ff - low_ff;
   assign mid          = low_ff + product_ff[ProdBits-1:PROB_BITS];
   assign diff         = low_ff ^ high_ff;

   // Count of leading bytes on which low and high agree
   always_comb begin
      if (diff[31:24] != '0) begin
         settled = 3'd0;
      end else if (diff[23:16] != '0) begin
         settled = 3'd1;
      end else if (diff[15:8] != '0) begin
         settled = 3'd2;
      end else if (diff[7:0] != '0) begin
         settled = 3'd3;
      end else begin
         settled = 3'd4;
      end
   end

   always_comb begin
      state_in   = state_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      product_in = product_ff;
      bit_in     = bit_ff;
      flush_in   = flush_ff;
      push       = 1'b0;
      push_job   = '{data: high_ff, last_idx: 2'(settled - 3'd1)};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               flush_in   = (req_operation == bae_pkg::OpFlush);
               bit_in     = req_coded_bit;
               product_in = ProdBits'(span) * ProdBits'(prob_clamped);
               state_in   = (req_operation == bae_pkg::OpFlush) ? ST_NORM : ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (bit_ff) begin
               high_in = mid;
            end else begin
               low_in = mid + 32'd1;
            end
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (flush_ff) begin
               push_job = '{data: low_ff, last_idx: 2'd3};
               if (!queue_full) begin
                  push     = 1'b1;
                  low_in   = bae_pkg::LowReset;
                  high_in  = bae_pkg::HighReset;
                  state_in = ST_IDLE;
               end
            end else if (settled == 3'd0) begin
               state_in = ST_IDLE;
            end else if (!queue_full) begin
               push     = 1'b1;
               state_in = ST_IDLE;
               case (settled)
                  3'd1: begin
                     low_in  = {low_ff[23:0], 8'h00};
                     high_in = {high_ff[23:0], bae_pkg::ByteFill};
                  end
                  3'd2: begin
                     low_in  = {low_ff[15:0], 16'h0000};
                     high_in = {high_ff[15:0], {2{bae_pkg::ByteFill}}};
                  end
                  3'd3: begin
                     low_in  = {low_ff[7:0], 24'h000000};
                     high_in = {high_ff[7:0], {3{bae_pkg::ByteFill}}};
                  end
                  default: begin
                     low_in  = bae_pkg::LowReset;
                     high_in = bae_pkg::HighReset;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         low_ff   <= bae_pkg::LowReset;
         high_ff  <= bae_pkg::HighReset;
      end else begin
         state_ff   <= state_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         product_ff <= product_in;
         bit_ff     <= bit_in;
         flush_ff   <= flush_in;
      end
   end

endmodule

// ===== rtl/core/bae_queue.sv =====
// ----------------------------------------------------------------------------
// bae_queue
// Small FIFO of byte jobs between the interval front and the byte emitter.
// ----------------------------------------------------------------------------
module bae_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bae_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output bae_pkg::job_type  head_job,
   output logic              empty
);

   localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntBits = $clog2(DEPTH + 1);

   bae_pkg::job_type    entry_ff [DEPTH];
   logic [PtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]  count_ff, count_in;

   assign full     = (count_ff == CntBits'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/bae_back.sv =====
// ----------------------------------------------------------------------------
// bae_back
// Splits queued jobs into bytes and drives the registered result channel.
// ----------------------------------------------------------------------------
module bae_back (
   input  logic              clock,
   input  logic              reset,
   input  bae_pkg::job_type  head_job,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_of_run
);

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        load;
   logic [7:0]  sel_byte;
   logic        sel_last;

   assign load     = !empty && (!valid_ff || !rsp_stall);
   assign sel_last = (idx_ff == head_job.last_idx);
   assign pop      = load && sel_last;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head_job.data[31:24];
         2'd1:    sel_byte = head_job.data[23:16];
         2'd2:    sel_byte = head_job.data[15:8];
         default: sel_byte = head_job.data[7:0];
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = sel_byte;
         last_in  = sel_last;
         idx_in   = sel_last ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
         byte_ff  <= byte_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== verif/bae_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// bae_tb_pkg
// Byte predictor and checker for the binary arithmetic encoder testbench.
// ----------------------------------------------------------------------------
// Keeps its own copy of the coding interval. It predicts the bytes that each
// accepted item produces and compares them with the bytes that leave the block.
// ----------------------------------------------------------------------------
package bae_tb_pkg;

   import bae_pkg::*;

   localparam int unsigned ProbBits        = 12;
   localparam int unsigned ProbMax         = (1 << ProbBits) - 1;
   localparam int          MaxBytesPerItem = 4;
   localparam int unsigned ReportLimit     = 10;

   typedef struct packed {
      logic [ByteBits-1:0] out_byte;
      logic                last_of_run;
   } coded_byte_type;

   class coder_byte_checker;

      logic [IntervalBits-1:0] low_bound;
      logic [IntervalBits-1:0] high_bound;
      coded_byte_type          expected_bytes[$];
      int unsigned             error_count;

      function new();
         low_bound   = LowReset;
         high_bound  = HighReset;
         error_count = 0;
      endfunction

      function void note_error(input string what);
         error_count++;
         if (error_count <= ReportLimit) begin
            $display("ERROR: %s", what);
         end
      endfunction

      // Split [lo, hi] under the clamped probability and keep the side of the bit.
      function void split_interval(input logic [IntervalBits-1:0] lo,
                                   input logic [IntervalBits-1:0] hi,
                                   input logic coded_bit,
                                   input logic [ProbBits-1:0] prob,
                                   output logic [IntervalBits-1:0] new_lo,
                                   output logic [IntervalBits-1:0] new_hi);
         int unsigned                      prob_used;
         logic [IntervalBits-1:0]          span;
         logic [IntervalBits+ProbBits-1:0] product;
         logic [IntervalBits-1:0]          mid;
         prob_used = prob;
         if (prob_used < 1) prob_used = 1;
         if (prob_used > ProbMax) prob_used = ProbMax;
         span    = hi - lo;
         product = span * prob_used;
         mid     = lo + product[IntervalBits+ProbBits-1:ProbBits];
         new_lo  = lo;
         new_hi  = hi;
         if (coded_bit) begin
            new_hi = mid;
         end else begin
            new_lo = mid + 1'b1;
         end
      endfunction

      // Accepted input transfer: queue the bytes it settles.
      function void note_item(input logic operation, input logic coded_bit,
                              input logic [ProbBits-1:0] prob);
         coded_byte_type emitted [MaxBytesPerItem];
         int             count;
         count = 0;
         if (operation == OpFlush) begin
            for (int i = 0; i < MaxBytesPerItem; i++) begin
               emitted[count] = '{out_byte: low_bound[31:24], last_of_run: 1'b0};
               count++;
               low_bound = low_bound << ByteBits;
            end
            low_bound  = LowReset;
            high_bound = HighReset;
         end else begin
            split_interval(low_bound, high_bound, coded_bit, prob, low_bound, high_bound);
            while (count < MaxBytesPerItem && low_bound[31:24] == high_bound[31:24]) begin
               emitted[count] = '{out_byte: high_bound[31:24], last_of_run: 1'b0};
               count++;
               low_bound  = low_bound << ByteBits;
               high_bound = {high_bound[IntervalBits-ByteBits-1:0], ByteFill};
            end
         end
         for (int i = 0; i < count; i++) begin
            emitted[i].last_of_run = (i == count - 1);
            expected_bytes.insert(expected_bytes.size(), emitted[i]);
         end
      endfunction

      // Accepted output transfer: compare with the oldest outstanding byte.
      function void check_byte(input logic [ByteBits-1:0] out_byte, input logic last_of_run);
         coded_byte_type want;
         if (expected_bytes.size() == 0) begin
            note_error($sformatf("unexpected byte %02h last %b", out_byte, last_of_run));
            return;
         end
         want = expected_bytes.pop_front();
         if (want.out_byte !== out_byte) begin
            note_error($sformatf("out_byte: expected %02h, got %02h", want.out_byte, out_byte));
         end
         if (want.last_of_run !== last_of_run) begin
            note_error($sformatf("last_of_run on byte %02h: expected %b, got %b",
                                 want.out_byte, want.last_of_run, last_of_run));
         end
      endfunction

      function void check_drained();
         if (expected_bytes.size() != 0) begin
            note_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
         end
      endfunction

   endclass

endpackage

// ===== verif/binary_arithmetic_encoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_top_tb
// Self-checking testbench for the carryless binary arithmetic encoder.
// ----------------------------------------------------------------------------
// A directed prologue codes bits under the extreme probabilities (including a
// zero probability), flushes fresh and used intervals, and steers the interval
// until it collapses to a single value so that one bit releases four bytes.
// Random traffic follows: mostly bits that agree with their probability, with
// skewed and uniform probabilities and occasional flushes. The sender works in
// bursts, the receiver stalls in changing modes, and every byte is checked
// against a predicted stream.
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import bae_pkg::*;
   import bae_tb_pkg::*;

   localparam int unsigned HalfPeriod  = 5;
   localparam int unsigned ResetCycles = 11;
   localparam int unsigned RandomItems = 320;
   localparam int unsigned DrainCycles = 40;
   localparam int unsigned SteerSteps  = 12;

   typedef enum logic [1:0] {
      StallNever,
      StallLight,
      StallHeavy,
      StallPeriodic
   } stall_mode_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_operation;
   logic                req_coded_bit;
   logic [ProbBits-1:0] req_probability_one;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [ByteBits-1:0] rsp_out_byte;
   logic                rsp_last_of_run;

   coder_byte_checker byte_check;

   binary_arithmetic_encoder_top #(
      .PROB_BITS(ProbBits)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_coded_bit      (req_coded_bit),
      .req_probability_one(req_probability_one),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always begin
      #HalfPeriod clock = 1'b1;
      #HalfPeriod clock = 1'b0;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("binary_arithmetic_encoder_top verification failed");
      $finish;
   end

   // One input transfer. Called at a falling edge; returns at the falling edge
   // after acceptance with req_valid still high, so back-to-back transfers
   // never drop valid in between.
   task automatic send_item(input logic operation, input logic coded_bit,
                            input logic [ProbBits-1:0] prob);
      req_valid           <= 1'b1;
      req_operation       <= operation;
      req_coded_bit       <= coded_bit;
      req_probability_one <= prob;
      do @(posedge clock); while (req_stall);
      byte_check.note_item(operation, coded_bit, prob);
      @(negedge clock);
   endtask

   // Output monitor: values seen here are the ones present before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         byte_check.check_byte(rsp_out_byte, rsp_last_of_run);
      end
   end

   // Receiver back-pressure: modes picked at random, ranging from
   // free-flowing to mostly stalled, so stalls hit every phase of the queue.
   initial begin : stall_pattern
      stall_mode_type mode;
      int unsigned    stretch;
      int unsigned    period;
      rsp_stall = 1'b0;
      forever begin
         mode    = stall_mode_type'($urandom_range(0, 3));
         stretch = $urandom_range(16, 96);
         period  = $urandom_range(2, 5);
         for (int c = 0; c < stretch; c++) begin
            @(negedge clock);
            case (mode)
               StallNever: begin
                  rsp_stall <= 1'b0;
               end
               StallLight: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               StallHeavy: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_stall <= ((c % period) == 0);
               end
            endcase
         end
      end
   end

   initial begin : stimulus
      logic                    operation;
      logic                    coded_bit;
      logic [ProbBits-1:0]     prob;
      logic [IntervalBits-1:0] trial_low;
      logic [IntervalBits-1:0] trial_high;
      logic [IntervalBits-1:0] best_span;
      logic                    best_bit;
      logic [ProbBits-1:0]     best_prob;
      logic                    collapsed;
      int unsigned             sent;
      int unsigned             burst;
      int unsigned             gap;

      reset               = 1'b1;
      req_valid           = 1'b0;
      req_operation       = OpCodeBit;
      req_coded_bit       = 1'b0;
      req_probability_one = '0;
      byte_check          = new();

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed prologue ----
      // zero probability is taken as the smallest one
      send_item(OpCodeBit, 1'b1, '0);
      send_item(OpCodeBit, 1'b0, '0);
      // largest probability, both bits
      send_item(OpCodeBit, 1'b1, ProbBits'(ProbMax));
      send_item(OpCodeBit, 1'b0, ProbBits'(ProbMax));
      send_item(OpCodeBit, 1'b0, ProbBits'(ProbMax));
      send_item(OpCodeBit, 1'b1, ProbBits'(1 << (ProbBits - 1)));
      send_item(OpCodeBit, 1'b0, ProbBits'(1 << (ProbBits - 1)));
      // flush a used interval, then a fresh one back to back
      send_item(OpFlush, 1'b0, '0);
      send_item(OpFlush, 1'b1, ProbBits'(ProbMax));
      send_item(OpCodeBit, 1'b1, 12'hAAA);
      send_item(OpCodeBit, 1'b0, 12'h555);

      // Narrow the interval around a byte boundary without settling bytes,
      // until one bit can make low equal high and release four bytes at once.
      collapsed = 1'b0;
      for (int step = 0; step < SteerSteps && !collapsed; step++) begin
         best_span = HighReset;
         best_bit  = 1'b1;
         best_prob = ProbBits'(1);
         for (int cand = 0; cand < 2 * (ProbMax + 1) && !collapsed; cand++) begin
            byte_check.split_interval(byte_check.low_bound, byte_check.high_bound,
                                      cand[0], ProbBits'(cand >> 1), trial_low, trial_high);
            if (trial_low == trial_high) begin
               collapsed = 1'b1;
               best_bit  = cand[0];
               best_prob = ProbBits'(cand >> 1);
            end else if (trial_low[31:24] != trial_high[31:24] &&
                         trial_high - trial_low < best_span) begin
               best_span = trial_high - trial_low;
               best_bit  = cand[0];
               best_prob = ProbBits'(cand >> 1);
            end
         end
         send_item(OpCodeBit, best_bit, best_prob);
      end
      send_item(OpFlush, 1'b0, ProbBits'(ProbMax));

      // ---- random traffic in bursts ----
      sent = 0;
      while (sent < RandomItems) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < RandomItems; k++) begin
            operation = ($urandom_range(0, 23) == 0) ? OpFlush : OpCodeBit;
            case ($urandom_range(0, 4))
               0, 1: begin
                  prob = ProbBits'($urandom);
               end
               2: begin
                  prob = ProbBits'($urandom_range(0, 63));
               end
               3: begin
                  prob = ProbBits'($urandom_range(ProbMax - 63, ProbMax));
               end
               default: begin
                  prob = ProbBits'($urandom_range(1024, 3072));
               end
            endcase
            // mostly bits that follow their probability, like a real model
            // supplies; the rest are surprises that shrink the interval hard
            if ($urandom_range(0, 9) < 7) begin
               coded_bit = ($urandom_range(0, ProbMax) < prob);
            end else begin
               coded_bit = 1'($urandom_range(0, 1));
            end
            send_item(operation, coded_bit, prob);
            sent++;
         end
         // gap between bursts: often none, sometimes long enough to drain
         case ($urandom_range(0, 7))
            0, 1: gap = 0;
            2:    gap = $urandom_range(10, 24);
            default: gap = $urandom_range(1, 6);
         endcase
         if (gap != 0) begin
            req_valid           <= 1'b0;
            req_coded_bit       <= 1'($urandom_range(0, 1));
            req_probability_one <= ProbBits'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b0;

      // ---- drain ----
      while (byte_check.expected_bytes.size() != 0) @(posedge clock);
      // catch stray bytes after the last expected one
      repeat (DrainCycles) @(posedge clock);
      byte_check.check_drained();

      if (byte_check.error_count == 0) begin
         $display("binary_arithmetic_encoder_top verification clean");
      end else begin
         $display("binary_arithmetic_encoder_top verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/bae_pkg.sv
rtl/core/bae_front.sv
rtl/core/bae_queue.sv
rtl/core/bae_back.sv
rtl/core/binary_arithmetic_encoder_top.sv
verif/bae_tb_pkg.sv
verif/binary_arithmetic_encoder_top_tb.sv
